FILE: sv/gbn_pkg.sv
// gbn_pkg: shared constants, codes and types of the go-back-n sender
// no dependencies; used by every module of the block
package gbn_pkg;

	localparam int MAX_WINDOW  = 32;
	localparam int SEQ_BITS    = 16;
	localparam int WIN_W       = 6;
	localparam int TICK_W      = 16;
	localparam int RETRANS_W   = 24;
	localparam int RESULT_CAP  = 32;
	localparam int CNT_W       = $clog2(RESULT_CAP + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [RETRANS_W-1:0] RETRANS_MAX   = {RETRANS_W{1'b1}};
	localparam logic [WIN_W-1:0]     WINDOW_RESET  = WIN_W'(1);
	localparam logic [TICK_W-1:0]    TIMEOUT_RESET = TICK_W'(150);

	// input item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_ACK   = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	// register indexes
	localparam logic [1:0] REG_WINDOW  = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_MSGCNT  = 2'd2;

	typedef struct packed {
		logic [WIN_W-1:0]    window_size;
		logic [TICK_W-1:0]   timeout_ticks;
		logic [SEQ_BITS-1:0] message_count;
	} cfg_t;

	// one job per accepted item: the run of sends it causes and its status
	typedef struct packed {
		logic [SEQ_BITS-1:0]  start_seq;
		logic [CNT_W-1:0]     count;
		logic [SEQ_BITS-1:0]  old_next;
		logic                 done;
		logic [RETRANS_W-1:0] retrans;
	} job_t;

	typedef enum logic {
		FR_ACCEPT,
		FR_PUSH
	} fr_state_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

endpackage

FILE: sv/gbn_fifo.sv
// gbn_fifo: short job queue between the front and the back
// depends on gbn_pkg for job_t and the queue depth
module gbn_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  gbn_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output gbn_pkg::job_t rd_data,
	output logic          empty
);

	gbn_pkg::job_t                   mem_q [gbn_pkg::QUEUE_DEPTH];
	logic [gbn_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [gbn_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [gbn_pkg::QCNT_W-1:0]      fill_q;

	assign full    = (fill_q == gbn_pkg::QCNT_W'(gbn_pkg::QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= (wr_ptr_q == gbn_pkg::QPTR_W'(gbn_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= (rd_ptr_q == gbn_pkg::QPTR_W'(gbn_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en && !full, rd_en && !empty})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: sv/gbn_front.sv
// gbn_front: accepts items, keeps the window state and classifies each item
// into a job for the queue; depends on gbn_pkg
module gbn_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gbn_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [gbn_pkg::SEQ_BITS-1:0]  ack_seq,
	output logic                          push,
	output gbn_pkg::job_t                 job,
	input  logic                          queue_full
);

	gbn_pkg::fr_state_t                  state_q, state_d;
	logic [gbn_pkg::SEQ_BITS-1:0]        base_q, base_d;
	logic [gbn_pkg::SEQ_BITS-1:0]        next_q, next_d;
	logic [gbn_pkg::SEQ_BITS-1:0]        old_next_q, old_next_d;
	logic [gbn_pkg::TICK_W-1:0]          tick_q, tick_d;
	logic [gbn_pkg::RETRANS_W-1:0]       resend_q, resend_d;
	logic                                running_q, running_d;
	logic                                accept;

	logic [gbn_pkg::SEQ_BITS-1:0]        outstanding;
	logic [gbn_pkg::SEQ_BITS-1:0]        base_inc;
	logic [gbn_pkg::TICK_W-1:0]          tick_inc;
	logic [gbn_pkg::TICK_W-1:0]          limit;
	logic [gbn_pkg::RETRANS_W:0]         resend_sum;
	logic [gbn_pkg::WIN_W-1:0]           eff_w;
	logic [gbn_pkg::WIN_W-1:0]           room;
	logic [gbn_pkg::SEQ_BITS-1:0]        avail;
	logic [gbn_pkg::CNT_W-1:0]           n_room;
	logic [gbn_pkg::CNT_W-1:0]           n_send;

	// handshake sequencing
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			gbn_pkg::FR_ACCEPT: begin
				in_ready = 1'b1;
				if (in_valid) state_d = gbn_pkg::FR_PUSH;
			end
			gbn_pkg::FR_PUSH: begin
				push = !queue_full;
				if (!queue_full) state_d = gbn_pkg::FR_ACCEPT;
			end
			default: state_d = gbn_pkg::FR_ACCEPT;
		endcase
	end

	assign accept = in_valid && in_ready;

	// state update for the item at the port
	assign outstanding = next_q - base_q;
	assign base_inc    = base_q + 1'b1;
	assign tick_inc    = tick_q + 1'b1;
	assign limit       = (cfg.timeout_ticks == '0) ? gbn_pkg::TICK_W'(1) : cfg.timeout_ticks;
	assign resend_sum  = {1'b0, resend_q} + (gbn_pkg::RETRANS_W + 1)'(outstanding);

	always_comb begin
		base_d     = base_q;
		next_d     = next_q;
		tick_d     = tick_q;
		resend_d   = resend_q;
		running_d  = running_q;
		old_next_d = '0;
		case (kind)
			gbn_pkg::KIND_START: begin
				base_d    = '0;
				next_d    = '0;
				tick_d    = '0;
				resend_d  = '0;
				running_d = (cfg.message_count != '0);
			end
			gbn_pkg::KIND_ACK: begin
				if (running_q && ack_seq == base_q && base_q < next_q) begin
					base_d = base_inc;
					tick_d = '0;
					if (base_inc >= cfg.message_count) running_d = 1'b0;
				end
			end
			gbn_pkg::KIND_TICK: begin
				if (running_q && outstanding != '0) begin
					tick_d = tick_inc;
					// timeout: go back to the base and count the resends
					if (tick_inc >= limit || tick_inc == '0) begin
						resend_d   = resend_sum[gbn_pkg::RETRANS_W] ? gbn_pkg::RETRANS_MAX :
							resend_sum[gbn_pkg::RETRANS_W-1:0];
						old_next_d = next_q;
						next_d     = base_q;
						tick_d     = '0;
					end
				end
			end
			default: ;
		endcase
	end

	// sends allowed now: limited by window room, messages left and result cap
	always_comb begin
		eff_w = cfg.window_size;
		if (cfg.window_size == '0) eff_w = gbn_pkg::WIN_W'(1);
		else if (cfg.window_size > gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW))
			eff_w = gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW);
		room  = (outstanding < gbn_pkg::SEQ_BITS'(eff_w)) ?
			eff_w - gbn_pkg::WIN_W'(outstanding) : '0;
		avail = (cfg.message_count > next_q) ? cfg.message_count - next_q : '0;
		n_room = (avail < gbn_pkg::SEQ_BITS'(room)) ? gbn_pkg::CNT_W'(avail) :
			gbn_pkg::CNT_W'(room);
		if (n_room > gbn_pkg::CNT_W'(gbn_pkg::RESULT_CAP))
			n_room = gbn_pkg::CNT_W'(gbn_pkg::RESULT_CAP);
		n_send = running_q ? n_room : '0;
	end

	always_comb begin
		job.start_seq = next_q;
		job.count     = n_send;
		job.old_next  = old_next_q;
		job.done      = !running_q && (base_q >= cfg.message_count);
		job.retrans   = resend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gbn_pkg::FR_ACCEPT;
			base_q     <= '0;
			next_q     <= '0;
			old_next_q <= '0;
			tick_q     <= '0;
			resend_q   <= '0;
			running_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				base_q     <= base_d;
				next_q     <= next_d;
				old_next_q <= old_next_d;
				tick_q     <= tick_d;
				resend_q   <= resend_d;
				running_q  <= running_d;
			end else if (push) begin
				next_q <= next_q + gbn_pkg::SEQ_BITS'(n_send);
			end
		end
	end

endmodule

FILE: sv/gbn_back.sv
// gbn_back: expands each queued job into result beats through an output register
// depends on gbn_pkg
module gbn_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gbn_pkg::job_t                  q_data,
	input  logic                           q_empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           send_valid,
	output logic [gbn_pkg::SEQ_BITS-1:0]   send_seq,
	output logic                           is_resend,
	output logic                           done_res,
	output logic [gbn_pkg::RETRANS_W-1:0]  retrans_count,
	output logic                           last
);

	gbn_pkg::bk_state_t             state_q, state_d;
	gbn_pkg::job_t                  cur_q;
	logic [gbn_pkg::CNT_W-1:0]      idx_q;
	logic                           out_valid_q;
	logic                           emit;
	logic                           can_load;
	logic                           r_send;
	logic [gbn_pkg::SEQ_BITS-1:0]   r_seq;
	logic                           r_resend;
	logic                           r_last;

	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		r_send   = (cur_q.count != '0);
		r_seq    = r_send ? cur_q.start_seq + gbn_pkg::SEQ_BITS'(idx_q) : '0;
		r_resend = r_send && (r_seq < cur_q.old_next);
		r_last   = !r_send || (idx_q == cur_q.count - 1'b1);
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		case (state_q)
			gbn_pkg::BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = gbn_pkg::BK_RUN;
				end
			end
			gbn_pkg::BK_RUN: begin
				if (can_load) begin
					emit = 1'b1;
					if (r_last) state_d = gbn_pkg::BK_IDLE;
				end
			end
			default: state_d = gbn_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbn_pkg::BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) idx_q <= '0;
			else if (emit && !r_last) idx_q <= idx_q + 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_data;
		if (emit) begin
			send_valid    <= r_send;
			send_seq      <= r_seq;
			is_resend     <= r_resend;
			done_res      <= cur_q.done;
			retrans_count <= cur_q.retrans;
			last          <= r_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/go_back_n_sender_unit.sv
// go_back_n_sender_unit: go-back-n window sender, top level with register port
// flow: the front takes an item and queues its job before it takes the next one; the back loads
// a job, then gives one beat a cycle while out_ready does not hold it, for max(1, sends) beats
// reset: window state, counters and queue clear; registers take their reset values
// depends on gbn_pkg, gbn_front, gbn_fifo, gbn_back
module go_back_n_sender_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gbn_pkg::ADDR_W-1:0]     paddr,
	input  logic [gbn_pkg::DATA_W-1:0]     pwdata,
	output logic [gbn_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	// input items
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [gbn_pkg::SEQ_BITS-1:0]   ack_seq,
	// result beats
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           send_valid,
	output logic [gbn_pkg::SEQ_BITS-1:0]   send_seq,
	output logic                           is_resend,
	output logic                           done_res,
	output logic [gbn_pkg::RETRANS_W-1:0]  retrans_count,
	output logic                           last
);

	gbn_pkg::cfg_t   cfg_q;
	gbn_pkg::job_t   push_job;
	gbn_pkg::job_t   head_job;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	logic            wr_hit;
	logic [1:0]      reg_idx;

	// register port: no wait states, word addressed
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_hit  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size   <= gbn_pkg::WINDOW_RESET;
			cfg_q.timeout_ticks <= gbn_pkg::TIMEOUT_RESET;
			cfg_q.message_count <= '0;
		end else if (wr_hit) begin
			case (reg_idx)
				gbn_pkg::REG_WINDOW:  cfg_q.window_size   <= pwdata[gbn_pkg::WIN_W-1:0];
				gbn_pkg::REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[gbn_pkg::TICK_W-1:0];
				gbn_pkg::REG_MSGCNT:  cfg_q.message_count <= pwdata[gbn_pkg::SEQ_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		case (reg_idx)
			gbn_pkg::REG_WINDOW:  prdata = gbn_pkg::DATA_W'(cfg_q.window_size);
			gbn_pkg::REG_TIMEOUT: prdata = gbn_pkg::DATA_W'(cfg_q.timeout_ticks);
			gbn_pkg::REG_MSGCNT:  prdata = gbn_pkg::DATA_W'(cfg_q.message_count);
			default:              prdata = '0;
		endcase
	end

	// front: takes the item, updates base, next, timer and resend total at the
	// accepting edge, then in its push state sizes the send run and queues the job once the queue has room
	gbn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.ack_seq    (ack_seq),
		.push       (push),
		.job        (push_job),
		.queue_full (q_full)
	);

	// two jobs of slack so the front keeps accepting while the back drains a window
	gbn_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_job),
		.full    (q_full),
		.rd_en   (pop),
		.rd_data (head_job),
		.empty   (q_empty)
	);

	// back: one result beat per cycle into the output register while the receiver takes them, last on the final one
	gbn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_data        (head_job),
		.q_empty       (q_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.send_valid    (send_valid),
		.send_seq      (send_seq),
		.is_resend     (is_resend),
		.done_res      (done_res),
		.retrans_count (retrans_count),
		.last          (last)
	);

endmodule

FILE: tb/testbench.sv
// testbench for go_back_n_sender_unit: directed rows, then randomized phases
// checked beat by beat against a window predictor; depends on gbn_pkg and the rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gbn_pkg::*;

	// kind code the block treats as a no-op
	localparam logic [1:0] KIND_NONE = 2'd3;

	// one result beat as the block presents it
	typedef struct packed {
		logic                 send_valid;
		logic [SEQ_BITS-1:0]  send_seq;
		logic                 is_resend;
		logic                 done_res;
		logic [RETRANS_W-1:0] retrans;
		logic                 last;
	} beat_t;

	typedef enum bit {
		ROW_ITEM,
		ROW_CFG
	} row_op_t;

	// a directed row is an item (sel = kind, value = ack_seq) or a register write
	// (sel = register index); fixed rows carry a hand-written single beat
	typedef struct packed {
		row_op_t    op;
		logic [1:0] sel;
		logic [31:0] value;
		bit         fixed;
		beat_t      want;
	} row_t;

	localparam int N_ROWS = 32;

	localparam row_t DIRECTED_ROWS [N_ROWS] = '{
		// out of reset: count 0, so every item is a status beat with done set
		'{ROW_ITEM, KIND_TICK,  32'h0000, 1'b1, '{1'b0, 16'd0, 1'b0, 1'b1, 24'd0, 1'b1}},
		'{ROW_ITEM, KIND_ACK,   32'hFFFF, 1'b1, '{1'b0, 16'd0, 1'b0, 1'b1, 24'd0, 1'b1}},
		'{ROW_ITEM, KIND_NONE,  32'hAAAA, 1'b1, '{1'b0, 16'd0, 1'b0, 1'b1, 24'd0, 1'b1}},
		// start with nothing to deliver finishes at once
		'{ROW_ITEM, KIND_START, 32'h5555, 1'b1, '{1'b0, 16'd0, 1'b0, 1'b1, 24'd0, 1'b1}},
		// three messages through a window of one
		'{ROW_CFG,  REG_MSGCNT, 32'd3,    1'b0, '0},
		'{ROW_ITEM, KIND_START, 32'h0000, 1'b1, '{1'b1, 16'd0, 1'b0, 1'b0, 24'd0, 1'b1}},
		'{ROW_ITEM, KIND_ACK,   32'd1,    1'b1, '{1'b0, 16'd0, 1'b0, 1'b0, 24'd0, 1'b1}},
		'{ROW_ITEM, KIND_ACK,   32'd0,    1'b1, '{1'b1, 16'd1, 1'b0, 1'b0, 24'd0, 1'b1}},
		// zero window and zero timeout both behave as one
		'{ROW_CFG,  REG_WINDOW, 32'd0,    1'b0, '0},
		'{ROW_CFG,  REG_TIMEOUT, 32'd0,   1'b0, '0},
		'{ROW_ITEM, KIND_TICK,  32'h0000, 1'b1, '{1'b1, 16'd1, 1'b1, 1'b0, 24'd1, 1'b1}},
		'{ROW_ITEM, KIND_ACK,   32'd1,    1'b1, '{1'b1, 16'd2, 1'b0, 1'b0, 24'd1, 1'b1}},
		'{ROW_ITEM, KIND_ACK,   32'd2,    1'b1, '{1'b0, 16'd0, 1'b0, 1'b1, 24'd1, 1'b1}},
		'{ROW_ITEM, KIND_TICK,  32'hFFFF, 1'b1, '{1'b0, 16'd0, 1'b0, 1'b1, 24'd1, 1'b1}},
		// oversized window saturates, full send bursts, timeout resend of the window
		'{ROW_CFG,  REG_WINDOW, 32'd63,   1'b0, '0},
		'{ROW_CFG,  REG_TIMEOUT, 32'd1,   1'b0, '0},
		'{ROW_CFG,  REG_MSGCNT, 32'd65535, 1'b0, '0},
		'{ROW_ITEM, KIND_START, 32'h0000, 1'b0, '0},
		'{ROW_ITEM, KIND_ACK,   32'd0,    1'b0, '0},
		'{ROW_ITEM, KIND_TICK,  32'h1234, 1'b0, '0},
		'{ROW_ITEM, KIND_ACK,   32'hFFFF, 1'b0, '0},
		// restart while running clears the retransmission total
		'{ROW_ITEM, KIND_START, 32'h0000, 1'b0, '0},
		// count lowered under the outstanding window
		'{ROW_CFG,  REG_MSGCNT, 32'd2,    1'b0, '0},
		'{ROW_ITEM, KIND_TICK,  32'h0000, 1'b0, '0},
		'{ROW_ITEM, KIND_ACK,   32'd0,    1'b0, '0},
		'{ROW_ITEM, KIND_ACK,   32'd1,    1'b0, '0},
		// largest timeout, window at its maximum
		'{ROW_CFG,  REG_WINDOW, 32'd32,   1'b0, '0},
		'{ROW_CFG,  REG_TIMEOUT, 32'd65535, 1'b0, '0},
		'{ROW_CFG,  REG_MSGCNT, 32'd40,   1'b0, '0},
		'{ROW_ITEM, KIND_START, 32'h0000, 1'b0, '0},
		'{ROW_ITEM, KIND_TICK,  32'h8001, 1'b0, '0},
		'{ROW_ITEM, KIND_NONE,  32'h0F0F, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [ADDR_W-1:0]     paddr     = '0;
	logic [DATA_W-1:0]     pwdata    = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [1:0]            kind      = KIND_TICK;
	logic [SEQ_BITS-1:0]   ack_seq   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  send_valid;
	logic [SEQ_BITS-1:0]   send_seq;
	logic                  is_resend;
	logic                  done_res;
	logic [RETRANS_W-1:0]  retrans_count;
	logic                  last;

	go_back_n_sender_unit u_top (.*);

	// predictor copy of the registers, at their reset values
	logic [WIN_W-1:0]     cfg_window  = WINDOW_RESET;
	logic [TICK_W-1:0]    cfg_timeout = TIMEOUT_RESET;
	logic [SEQ_BITS-1:0]  cfg_count   = '0;

	// predictor copy of the transfer state
	logic [SEQ_BITS-1:0]  base_seq   = '0;
	logic [SEQ_BITS-1:0]  next_out   = '0;
	logic [TICK_W-1:0]    ticks_seen = '0;
	logic [RETRANS_W-1:0] resend_sum = '0;
	bit                   xfer_on    = 1'b0;

	beat_t beats_due[$];
	int    mismatch_count = 0;
	int    beats_seen     = 0;

	// idle percentages of each side, and a long receiver hold on request
	int tx_pct   = 0;
	int rx_pct   = 0;
	bit hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit far beyond the slowest passing run
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at beat %0d: %s", beats_seen, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		end
	endtask

	function automatic beat_t status_beat(input logic sv, input logic [SEQ_BITS-1:0] seq,
			input logic rs);
		beat_t b;
		b.send_valid = sv;
		b.send_seq   = seq;
		b.is_resend  = rs;
		b.done_res   = !xfer_on && (base_seq >= cfg_count);
		b.retrans    = resend_sum;
		b.last       = 1'b0;
		return b;
	endfunction

	// completion is only looked at on start and on an in-order ack
	function automatic void settle_done();
		if (xfer_on && base_seq >= cfg_count) begin
			xfer_on = 1'b0;
		end
	endfunction

	// applies one accepted item to the window state and queues the beats it causes
	function automatic void advance_window(input logic [1:0] k, input logic [SEQ_BITS-1:0] a);
		int unsigned outstanding;
		int unsigned limit;
		int unsigned sum;
		int unsigned win;
		logic [SEQ_BITS-1:0] old_next;
		int produced;
		old_next = '0;
		produced = 0;
		case (k)
			KIND_START: begin
				base_seq   = '0;
				next_out   = '0;
				ticks_seen = '0;
				resend_sum = '0;
				xfer_on    = 1'b1;
				settle_done();
			end
			KIND_ACK: begin
				if (xfer_on && a == base_seq && base_seq < next_out) begin
					base_seq   = base_seq + 1'b1;
					ticks_seen = '0;
					settle_done();
				end
			end
			KIND_TICK: begin
				outstanding = 32'(next_out - base_seq);
				if (xfer_on && outstanding > 0) begin
					limit = (cfg_timeout == '0) ? 1 : 32'(cfg_timeout);
					ticks_seen = ticks_seen + 1'b1;
					if (ticks_seen >= limit || ticks_seen == 0) begin
						sum = 32'(resend_sum) + outstanding;
						resend_sum = (sum > RETRANS_MAX) ? RETRANS_MAX : sum[RETRANS_W-1:0];
						old_next   = next_out;
						next_out   = base_seq;
						ticks_seen = '0;
					end
				end
			end
			default: ;
		endcase
		win = (cfg_window == '0) ? 1 : (cfg_window > MAX_WINDOW) ? MAX_WINDOW : 32'(cfg_window);
		while (xfer_on && produced < RESULT_CAP && next_out < cfg_count
				&& 32'(next_out - base_seq) < win) begin
			beats_due.push_back(status_beat(1'b1, next_out, next_out < old_next));
			next_out = next_out + 1'b1;
			produced++;
		end
		if (produced == 0) begin
			beats_due.push_back(status_beat(1'b0, '0, 1'b0));
		end
		beats_due[beats_due.size()-1].last = 1'b1;
	endfunction

	// offers one item with random lead-in idling; returns at the accepting edge
	task automatic offer_item(input logic [1:0] k, input logic [SEQ_BITS-1:0] a);
		while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		ack_seq  <= a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// registers change only with nothing in flight
	task automatic drain();
		in_valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// setup cycle, then access cycle, then the port returns to idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_WINDOW:  cfg_window  = val[WIN_W-1:0];
			REG_TIMEOUT: cfg_timeout = val[TICK_W-1:0];
			REG_MSGCNT:  cfg_count   = val[SEQ_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// receiver: random stalls per phase, plus a long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = 400;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !(rx_pct != 0 && $urandom_range(99) < rx_pct);
			end
		end
	end

	// result monitor: every accepted beat against the oldest expectation
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (beats_due.size() == 0) begin
				flag_mismatch("beat with nothing expected");
			end else begin
				want = beats_due.pop_front();
				check_field("send_valid", 32'(send_valid), 32'(want.send_valid));
				check_field("send_seq", 32'(send_seq), 32'(want.send_seq));
				check_field("is_resend", 32'(is_resend), 32'(want.is_resend));
				check_field("done_res", 32'(done_res), 32'(want.done_res));
				check_field("retrans_count", 32'(retrans_count), 32'(want.retrans));
				check_field("last", 32'(last), 32'(want.last));
			end
			beats_seen++;
		end
	end

	initial begin
		int phase;
		int roll;
		logic [1:0] k;
		logic [SEQ_BITS-1:0] a;
		logic [31:0] v;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, no idling on either side
		for (int r = 0; r < N_ROWS; r++) begin
			if (DIRECTED_ROWS[r].op == ROW_CFG) begin
				drain();
				write_reg(DIRECTED_ROWS[r].sel, DIRECTED_ROWS[r].value);
			end else begin
				offer_item(DIRECTED_ROWS[r].sel, DIRECTED_ROWS[r].value[SEQ_BITS-1:0]);
				if (DIRECTED_ROWS[r].fixed) begin
					// state still moves, but the beat checked is the written one
					roll = beats_due.size();
					advance_window(DIRECTED_ROWS[r].sel, DIRECTED_ROWS[r].value[SEQ_BITS-1:0]);
					while (beats_due.size() > roll) void'(beats_due.pop_back());
					beats_due.push_back(DIRECTED_ROWS[r].want);
				end else begin
					advance_window(DIRECTED_ROWS[r].sel, DIRECTED_ROWS[r].value[SEQ_BITS-1:0]);
				end
			end
		end

		// random phases: new settings, then mostly well-formed traffic
		for (phase = 0; phase < 8; phase++) begin
			drain();
			case ($urandom_range(5))
				0: v = 0;
				1: v = 63;
				2: v = 32;
				default: v = $urandom_range(1, 12);
			endcase
			write_reg(REG_WINDOW, v);
			case ($urandom_range(5))
				0: v = 0;
				1: v = 65535;
				default: v = $urandom_range(1, 6);
			endcase
			write_reg(REG_TIMEOUT, v);
			case ($urandom_range(6))
				0: v = 0;
				1: v = 65535;
				2: v = 1;
				default: v = $urandom_range(2, 60);
			endcase
			write_reg(REG_MSGCNT, v);

			// cycle through the idling mixes
			case (phase % 4)
				0: begin tx_pct = 0;  rx_pct = 0;  end
				1: begin tx_pct = 62; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 62; end
				default: begin tx_pct = 17; rx_pct = 17; end
			endcase
			// once, the receiver holds off while items keep coming so the block backs up
			if (phase == 4) hold_req = 1'b1;

			// usually a fresh transfer; otherwise carry on under the new settings
			if ($urandom_range(99) < 80) begin
				a = SEQ_BITS'($urandom_range(16'hFFFF));
				offer_item(KIND_START, a);
				advance_window(KIND_START, a);
			end
			for (int i = 0; i < 13; i++) begin
				roll = $urandom_range(99);
				if (roll < 45) begin
					k = KIND_ACK;
					a = base_seq;
				end else if (roll < 72) begin
					k = KIND_TICK;
					a = SEQ_BITS'($urandom_range(16'hFFFF));
				end else if (roll < 80) begin
					// near miss: just ahead of or behind the base
					k = KIND_ACK;
					a = ($urandom_range(1) != 0) ?
						base_seq + SEQ_BITS'($urandom_range(1, 3)) : base_seq - 1'b1;
				end else if (roll < 87) begin
					k = KIND_ACK;
					a = SEQ_BITS'($urandom_range(16'hFFFF));
				end else if (roll < 93) begin
					k = KIND_NONE;
					a = SEQ_BITS'($urandom_range(16'hFFFF));
				end else begin
					k = KIND_START;
					a = SEQ_BITS'($urandom_range(16'hFFFF));
				end
				offer_item(k, a);
				advance_window(k, a);
			end
		end

		// wait out everything still expected, then a short settle
		in_valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
